[design/gcm_pkg.sv]
`default_nettype none
package gcm_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned NUM_CHARS = 16;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned APB_DW    = 64;
  localparam int unsigned APB_AW    = 5;

  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;  // '*'
  localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;  // '?'

  // input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_CHAR  = 1'b1;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_LENGTH     = 2'd0,
    REG_CHARS_LOW  = 2'd1,
    REG_CHARS_HIGH = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [LEN_W-1:0]                 length;
    logic [NUM_CHARS-1:0][CHAR_W-1:0] chars;
  } cfg_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              advance;
    logic              start;
    logic [CHAR_W-1:0] ch;
  } ctrl_t;

endpackage
`default_nettype wire

[design/gcm_in_if.sv]
`default_nettype none
interface gcm_in_if;
  import gcm_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [CHAR_W-1:0] character;

  modport source (output valid, command, character, input ready);
  modport sink   (input valid, command, character, output ready);
endinterface
`default_nettype wire

[design/gcm_out_if.sv]
`default_nettype none
interface gcm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic may_still_match;

  modport source (output valid, matched, may_still_match, input ready);
  modport sink   (input valid, matched, may_still_match, output ready);
endinterface
`default_nettype wire

[design/gcm_cfg.sv]
`default_nettype none
module gcm_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gcm_pkg::APB_AW-1:0] paddr,
  input  wire logic [gcm_pkg::APB_DW-1:0] pwdata,
  output logic      [gcm_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output gcm_pkg::cfg_t                   cfg_o
);
  import gcm_pkg::*;

  logic [LEN_W-1:0]  length_q;
  logic [APB_DW-1:0] chars_low_q;
  logic [APB_DW-1:0] chars_high_q;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:3]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q     <= '0;
      chars_low_q  <= '0;
      chars_high_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_LENGTH:     length_q     <= pwdata[LEN_W-1:0];
        REG_CHARS_LOW:  chars_low_q  <= pwdata;
        REG_CHARS_HIGH: chars_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LENGTH:     prdata = {{(APB_DW-LEN_W){1'b0}}, length_q};
      REG_CHARS_LOW:  prdata = chars_low_q;
      REG_CHARS_HIGH: prdata = chars_high_q;
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.length = length_q;
  assign cfg_o.chars  = {chars_high_q, chars_low_q};

endmodule
`default_nettype wire

[design/gcm_cell.sv]
`default_nettype none
module gcm_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire gcm_pkg::ctrl_t             ctrl_i,
  input  wire logic [gcm_pkg::CHAR_W-1:0] pat_char_i,
  input  wire logic                       enable_i,
  input  wire logic                       old_prev_i,
  input  wire logic                       new_prev_i,
  output logic                            bit_o,
  output logic                            new_bit_o
);
  import gcm_pkg::*;

  logic bit_q;
  logic bit_d;
  logic is_star;
  logic hit;

  assign is_star = (pat_char_i == CHAR_STAR);
  assign hit     = (pat_char_i == CHAR_QMARK) || (pat_char_i == ctrl_i.ch);

  // star is checked before the literal compare, so a '*' pattern byte never takes the literal path
  always_comb begin
    if (!enable_i) begin
      bit_d = 1'b0;
    end else if (ctrl_i.start) begin
      bit_d = is_star && new_prev_i;
    end else if (is_star) begin
      bit_d = bit_q || new_prev_i;
    end else begin
      bit_d = hit && old_prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (ctrl_i.advance) begin
      bit_q <= bit_d;
    end
  end

  assign bit_o     = bit_q;
  assign new_bit_o = bit_d;

endmodule
`default_nettype wire

[design/wildcard_glob_matcher.sv]
`default_nettype none
// Streaming glob matcher. Program pattern_length and the two character words over
// APB (registers at byte addresses 0x00, 0x08, 0x10, 64-bit data), then send items:
// command 0 starts a new source string, command 1 feeds one character. Every item
// returns one result in the cycle after it is accepted: matched (the source so far
// matches the whole pattern) and may_still_match (some partial match is alive). '?'
// matches any one byte, '*' matches any run; every other byte, zero included,
// matches itself. A length above PATTERN_MAX is treated as PATTERN_MAX. It takes
// one item per clock unless the result side stalls: the row of PATTERN_MAX cells
// updates together, the star carry rippling from cell to cell, and an output
// register decouples the result side. Before the first start only row bit 0 is set.
module wildcard_glob_matcher #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  gcm_in_if.sink                          in_ch,
  gcm_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gcm_pkg::APB_AW-1:0] paddr,
  input  wire logic [gcm_pkg::APB_DW-1:0] pwdata,
  output logic      [gcm_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import gcm_pkg::*;

  localparam int unsigned IDX_W = $clog2(PATTERN_MAX + 1);

  cfg_t                 cfg;
  ctrl_t                ctrl;
  logic [LEN_W-1:0]     len_used;
  logic [IDX_W-1:0]     len_idx;
  logic                 accept;

  // row bit 0 lives here; bits 1..PATTERN_MAX live in the cells
  logic                 row0_q;
  logic                 row0_d;
  logic [PATTERN_MAX:0] row_cur;
  logic [PATTERN_MAX:0] row_new;

  logic                 out_valid_q;
  logic                 matched_q;
  logic                 may_q;

  gcm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign len_used = (cfg.length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : cfg.length;
  assign len_idx  = len_used[IDX_W-1:0];

  // accept while the output slot is empty or being drained
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign ctrl.advance = accept;
  assign ctrl.start   = (in_ch.command == CMD_START);
  assign ctrl.ch      = in_ch.character;

  assign row0_d     = ctrl.start;
  assign row_cur[0] = row0_q;
  assign row_new[0] = row0_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= 1'b1;
    end else if (accept) begin
      row0_q <= row0_d;
    end
  end

  for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
    gcm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .pat_char_i (cfg.chars[j-1]),
      .enable_i   (LEN_W'(j) <= len_used),
      .old_prev_i (row_cur[j-1]),
      .new_prev_i (row_new[j-1]),
      .bit_o      (row_cur[j]),
      .new_bit_o  (row_new[j])
    );
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      matched_q <= row_new[len_idx];
      may_q     <= |row_new;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.matched         = matched_q;
  assign out_ch.may_still_match = may_q;

  // a start leaves bit 0 set, a character clears it
  a_row0_follows_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (row0_q == $past(ctrl.start)))
    else $error("row bit 0 does not follow command");

  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item produced no result");

  a_match_implies_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && matched_q) |-> may_q)
    else $error("matched without any live row bit");

  a_start_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctrl.start) |=> may_q)
    else $error("start result reports no live match");

endmodule
`default_nettype wire
